[design/poct_pkg.sv]
// ============================================================================
// poct_pkg
// Shared types, constants and helpers for the partial order closure table.
// ============================================================================
package poct_pkg;

    // Matrix size and derived widths
    localparam int MAX_NODES = 64;
    localparam int ROW_AW    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int NODE_W    = 6;
    localparam int CFG_W     = 7;
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int NODE_COUNT_RESET = 64;

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [ROW_AW-1:0]    row_idx_t;
    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    typedef enum logic [1:0] {
        OP_SET_LESS = 2'd0,
        OP_GET_REL  = 2'd1,
        OP_IS_MIN   = 2'd2,
        OP_DEL_MIN  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_LESS    = 2'd1,
        REL_GREATER = 2'd2
    } rel_t;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_SELF    = 3'd1,
        ERR_CYCLE   = 3'd2,
        ERR_NOT_MIN = 3'd3,
        ERR_RANGE   = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_A,
        S_CHK_B,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef enum logic {
        ROW_SET,
        ROW_CLEAR
    } row_mode_t;

    typedef struct packed {
        op_t   op;
        node_t first_node;
        node_t second_node;
    } req_t;

    typedef struct packed {
        rel_t  relation;
        logic  is_min;
        err_t  error_code;
    } rsp_t;

    // Control from the sequencer to the row unit
    typedef struct packed {
        row_mode_t mode;
        row_idx_t  a_idx;
        row_idx_t  b_idx;
        logic      is_b;
    } row_ctrl_t;

    // Status from the row unit back to the sequencer
    typedef struct packed {
        logic we;
        logic bit_a;
        logic bit_b;
        logic empty;
    } row_stat_t;

    // Map a node field onto a matrix row index
    function automatic row_idx_t to_row(input node_t n);
        return row_idx_t'(n);
    endfunction

    // True when a node index lies below the active limit
    function automatic logic in_range(input node_t n, input cmp_t limit);
        return cmp_t'(n) < limit;
    endfunction

endpackage

[design/poct_ram.sv]
// ============================================================================
// poct_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module poct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/poct_row_unit.sv]
// ============================================================================
// poct_row_unit
// Shared row datapath: tests bits of one matrix row and builds its update.
// ============================================================================
module poct_row_unit
    import poct_pkg::*;
(
    input  row_ctrl_t ctrl,
    input  row_t      row,
    input  row_t      low_side,
    output row_t      new_row,
    output row_stat_t stat
);

    // Test the bits the sequencer asks about, build the updated row and
    // decide whether it is written back
    always_comb
    begin
        stat.bit_a = row[ctrl.a_idx];
        stat.bit_b = row[ctrl.b_idx];
        stat.empty = (row == '0);
        unique case (ctrl.mode)
            ROW_SET:
            begin
                new_row = row | low_side;
                stat.we = ctrl.is_b | row[ctrl.b_idx];
            end
            ROW_CLEAR:
            begin
                new_row = row & ~(row_t'(1) << ctrl.a_idx);
                stat.we = row[ctrl.a_idx];
            end
            default:
            begin
                new_row = row;
                stat.we = 1'b0;
            end
        endcase
    end

endmodule

[design/partial_order_closure_table.sv]
// ============================================================================
// partial_order_closure_table
// Transitively closed strict partial order over up to MAX_NODES nodes.
// ============================================================================
// Usage:
//   req channel (req_valid/req_ready/req) carries one request: op, first_node,
//   second_node. rsp channel (rsp_valid/rsp_ready/rsp) returns one result per
//   request: relation, is_min, error_code. cfg channel writes node_count.
//   An accepted set-less or delete-min sweeps every matrix RAM row once, one
//   row per cycle, reading row x while writing back row x-1 via the row unit.
//   One request is in flight at a time; req_ready is high only when idle.
//   A finished result waits in the output register; req_ready returns as
//   soon as the result is loaded there, even while rsp_ready is low.
//   Reset clears one valid flag per matrix row, so the whole matrix reads as
//   zero at once; no clearing pass is needed. node_count resets to 64.
//   cfg_ready is always high; write only while the block is idle.
// ============================================================================
module partial_order_closure_table
    import poct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    row_idx_t         a_reg, a_next;
    row_idx_t         b_reg, b_next;
    row_t             low_reg, low_next;
    rel_t             rel_reg, rel_next;
    logic             is_min_reg, is_min_next;
    err_t             err_reg, err_next;
    logic             gt_reg, gt_next;
    cnt_t             cnt_reg, cnt_next;
    logic             wb_valid_reg, wb_valid_next;
    row_idx_t         wb_addr_reg, wb_addr_next;
    logic             rd_valid_reg;
    row_t             row_valid_reg;
    logic [CFG_W-1:0] node_count_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    cmp_t      limit;
    logic      req_xfer;
    logic      pair_op;
    logic      range_bad;
    logic      slot_free;
    logic      sweep_issue;
    row_idx_t  ram_raddr;
    logic      ram_we;
    row_t      ram_rdata;
    row_t      row_cur;
    row_t      unit_row;
    row_ctrl_t unit_ctrl;
    row_stat_t unit_stat;

    // Active node limit, saturated at MAX_NODES
    always_comb
    begin
        if (cmp_t'(node_count_reg) > cmp_t'(MAX_NODES))
        begin
            limit = cmp_t'(MAX_NODES);
        end
        else
        begin
            limit = cmp_t'(node_count_reg);
        end
    end

    // Request checks
    assign req_ready   = (state_reg == S_IDLE);
    assign req_xfer    = req_valid & req_ready;
    assign pair_op     = (req.op == OP_SET_LESS) || (req.op == OP_GET_REL);
    assign range_bad   = !in_range(req.first_node, limit) ||
                         (pair_op && !in_range(req.second_node, limit));
    assign slot_free   = !rsp_valid_reg || rsp_ready;
    assign sweep_issue = (cnt_reg < cnt_t'(MAX_NODES));

    // Rows never written read as zero
    assign row_cur = rd_valid_reg ? ram_rdata : '0;

    // Row unit control
    always_comb
    begin
        unit_ctrl.mode  = (op_reg == OP_DEL_MIN) ? ROW_CLEAR : ROW_SET;
        unit_ctrl.a_idx = a_reg;
        unit_ctrl.b_idx = b_reg;
        unit_ctrl.is_b  = (wb_addr_reg == b_reg);
    end

    poct_row_unit u_row_unit (
        .ctrl     (unit_ctrl),
        .row      (row_cur),
        .low_side (low_reg),
        .new_row  (unit_row),
        .stat     (unit_stat)
    );

    // Read address select
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  ram_raddr = to_row(req.first_node);
            S_CHK_A: ram_raddr = b_reg;
            S_SWEEP: ram_raddr = cnt_reg[ROW_AW-1:0];
            default: ram_raddr = a_reg;
        endcase
    end

    // Write back during the sweep
    assign ram_we = (state_reg == S_SWEEP) && wb_valid_reg && unit_stat.we;

    poct_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wb_addr_reg),
        .wdata (unit_row),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = range_bad ? S_DONE : S_CHK_A;
                end
            end
            S_CHK_A:
            begin
                unique case (op_reg)
                    OP_SET_LESS:
                    begin
                        if ((a_reg == b_reg) || unit_stat.bit_b)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SWEEP;
                        end
                    end
                    OP_GET_REL:  state_next = S_CHK_B;
                    OP_IS_MIN:   state_next = S_DONE;
                    OP_DEL_MIN:  state_next = unit_stat.empty ? S_SWEEP : S_DONE;
                    default:     state_next = S_DONE;
                endcase
            end
            S_CHK_B:
            begin
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                if (!sweep_issue && !wb_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        low_next       = low_reg;
        rel_next       = rel_reg;
        is_min_next    = is_min_reg;
        err_next       = err_reg;
        gt_next        = gt_reg;
        cnt_next       = cnt_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                // Capture the request and its range check
                if (req_xfer)
                begin
                    op_next     = req.op;
                    a_next      = to_row(req.first_node);
                    b_next      = to_row(req.second_node);
                    rel_next    = REL_NONE;
                    is_min_next = 1'b0;
                    err_next    = range_bad ? ERR_RANGE : ERR_OK;
                end
            end
            S_CHK_A:
            begin
                cnt_next = '0;
                unique case (op_reg)
                    OP_SET_LESS:
                    begin
                        if (a_reg == b_reg)
                        begin
                            err_next = ERR_SELF;
                        end
                        else if (unit_stat.bit_b)
                        begin
                            err_next = ERR_CYCLE;
                        end
                        low_next = row_cur | (row_t'(1) << a_reg);
                    end
                    OP_GET_REL:
                    begin
                        gt_next = unit_stat.bit_b;
                    end
                    OP_IS_MIN:
                    begin
                        is_min_next = unit_stat.empty;
                    end
                    OP_DEL_MIN:
                    begin
                        if (unit_stat.empty)
                        begin
                            is_min_next = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_NOT_MIN;
                        end
                    end
                    default:
                    begin
                        err_next = err_reg;
                    end
                endcase
            end
            S_CHK_B:
            begin
                // Row b holds bit a exactly when a lies below b
                if (unit_stat.bit_a)
                begin
                    rel_next = REL_LESS;
                end
                else if (gt_reg)
                begin
                    rel_next = REL_GREATER;
                end
                else
                begin
                    rel_next = REL_NONE;
                end
            end
            S_SWEEP:
            begin
                // Advance the read pointer; the row read now is written next cycle
                if (sweep_issue)
                begin
                    cnt_next      = cnt_reg + cnt_t'(1);
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cnt_reg[ROW_AW-1:0];
                end
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (slot_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.relation   = rel_reg;
                    rsp_next.is_min     = is_min_reg;
                    rsp_next.error_code = err_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            wb_valid_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            row_valid_reg  <= '0;
            node_count_reg <= CFG_W'(NODE_COUNT_RESET);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wb_valid_reg  <= wb_valid_next;
            rd_valid_reg  <= row_valid_reg[ram_raddr];
            rsp_valid_reg <= rsp_valid_next;
            if (ram_we)
            begin
                row_valid_reg[wb_addr_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        low_reg     <= low_next;
        rel_reg     <= rel_next;
        is_min_reg  <= is_min_next;
        err_reg     <= err_next;
        gt_reg      <= gt_next;
        wb_addr_reg <= wb_addr_next;
        rsp_reg     <= rsp_next;
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Write-back never hits the row being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (wb_addr_reg != ram_raddr))
        else $error("sweep write collides with read address");

    // Sweep pointer stays within the matrix plus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (cnt_reg <= cnt_t'(MAX_NODES)))
        else $error("sweep pointer out of range");

    // A relation is reported only for an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.relation != REL_NONE)) |-> (rsp.error_code == ERR_OK))
        else $error("relation reported with an error");

    // Relation and minimality never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.is_min && (rsp.relation != REL_NONE)))
        else $error("relation and is_min both set");

    // The matrix is only written during a set-less or delete-min sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (op_reg == OP_SET_LESS || op_reg == OP_DEL_MIN))
        else $error("matrix written by a read-only request");

endmodule

[tb/tb_partial_order_closure_table.sv]
// ============================================================================
// tb_partial_order_closure_table
// Self-checking bench for the partial order closure table. A local closure
// matrix predicts every answer at request transfer; a monitor compares each
// response transfer field by field. Directed order-building cases and
// node_count edges come first, then random traffic over several limits. The
// sender runs in bursts and the receiver stalls on its own pattern.
// ============================================================================
module tb_partial_order_closure_table;
    import poct_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = MAX_NODES + 16;
    localparam int PHASE_ITEMS  = 150;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Local copy of the order: row x holds bit y when y lies below x
    row_t             order_below [MAX_NODES];
    logic [CFG_W-1:0] nodes_in_use;
    rsp_t             pending_answers [$];
    rsp_t             next_answer;
    int unsigned      mismatch_count = 0;
    int unsigned      burst_left = 0;

    partial_order_closure_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Saturate node_count at the matrix size
    function automatic int unsigned live_limit();
        return (nodes_in_use > MAX_NODES) ? MAX_NODES : int'(nodes_in_use);
    endfunction

    function automatic node_t pick_node(input int unsigned lim);
        if (lim > 0)
            return node_t'($urandom_range(0, lim - 1));
        return node_t'($urandom_range(0, MAX_NODES - 1));
    endfunction

    // Apply one request to the local order and return its answer
    function automatic rsp_t apply_to_order(input req_t r);
        rsp_t        res;
        int unsigned lim;
        logic        pair;
        row_t        low_side;
        int          x;
        res.relation   = REL_NONE;
        res.is_min     = 1'b0;
        res.error_code = ERR_OK;
        lim  = live_limit();
        pair = (r.op == OP_SET_LESS) || (r.op == OP_GET_REL);
        if (r.first_node >= lim || (pair && r.second_node >= lim))
            res.error_code = ERR_RANGE;
        else
        begin
            case (r.op)
                OP_SET_LESS:
                begin
                    if (r.first_node == r.second_node)
                        res.error_code = ERR_SELF;
                    else if (order_below[r.first_node][r.second_node])
                        res.error_code = ERR_CYCLE;
                    else
                    begin
                        // Everything at or above b gains a and all below a
                        low_side = order_below[r.first_node];
                        low_side[r.first_node] = 1'b1;
                        for (x = 0; x < MAX_NODES; x++)
                            if (x == r.second_node || order_below[x][r.second_node])
                                order_below[x] |= low_side;
                    end
                end
                OP_GET_REL:
                begin
                    if (order_below[r.second_node][r.first_node])
                        res.relation = REL_LESS;
                    else if (order_below[r.first_node][r.second_node])
                        res.relation = REL_GREATER;
                end
                OP_IS_MIN:
                    res.is_min = (order_below[r.first_node] == '0);
                default:
                begin
                    if (order_below[r.first_node] != '0)
                        res.error_code = ERR_NOT_MIN;
                    else
                    begin
                        res.is_min = 1'b1;
                        for (x = 0; x < MAX_NODES; x++)
                            order_below[x][r.first_node] = 1'b0;
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %0d, actual %0d",
                     $realtime, what, want_v, got_v);
    endtask

    // Send one request, with random gaps between bursts
    task automatic send_request(input op_t kind, input node_t node_a, input node_t node_b);
        int unsigned gap;
        req_t        item;
        item.op          = kind;
        item.first_node  = node_a;
        item.second_node = node_b;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req       = item;
        req_valid = 1'b1;
        do @(posedge clk); while (!req_ready);
        pending_answers.push_back(apply_to_order(item));
    endtask

    // Drop valid and hold until every answer has come back
    task automatic wait_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_node_count(input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        nodes_in_use = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drive rsp_ready on runs of random kind and length
    initial
    begin : rsp_stall
        int unsigned pattern;
        int unsigned run;
        int unsigned hold;
        int unsigned i;
        rsp_ready = 1'b0;
        forever
        begin
            pattern = $urandom_range(0, 3);
            run     = $urandom_range(4, 40);
            hold    = $urandom_range(1, 12);
            for (i = 0; i < run; i++)
            begin
                @(negedge clk);
                case (pattern)
                    0:       rsp_ready = 1'b1;
                    1:       rsp_ready = 1'($urandom_range(0, 1));
                    2:       rsp_ready = (i % 3) != 0;
                    default: rsp_ready = (i >= hold);
                endcase
            end
        end
    end

    // Compare each response transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_answers.size() == 0)
                note_mismatch("response with nothing pending", 0, int'(rsp));
            else
            begin
                next_answer = pending_answers.pop_front();
                if (rsp.relation != next_answer.relation)
                    note_mismatch("relation", int'(next_answer.relation),
                                  int'(rsp.relation));
                if (rsp.is_min != next_answer.is_min)
                    note_mismatch("is_min", int'(next_answer.is_min), int'(rsp.is_min));
                if (rsp.error_code != next_answer.error_code)
                    note_mismatch("error_code", int'(next_answer.error_code),
                                  int'(rsp.error_code));
            end
        end
    end

    // Build and query a small order at the full node count
    task automatic test_basic_ops();
        send_request(OP_SET_LESS, 6'd0,  6'd63);
        send_request(OP_GET_REL,  6'd0,  6'd63);
        send_request(OP_GET_REL,  6'd63, 6'd0);
        send_request(OP_SET_LESS, 6'd63, 6'd0);   // reverse pair: cycle
        send_request(OP_SET_LESS, 6'd0,  6'd63);  // already ordered: no change
        send_request(OP_SET_LESS, 6'd5,  6'd5);   // self relation
        send_request(OP_SET_LESS, 6'd10, 6'd20);
        send_request(OP_SET_LESS, 6'd20, 6'd30);
        send_request(OP_GET_REL,  6'd10, 6'd30);  // implied by closure
        send_request(OP_SET_LESS, 6'd30, 6'd10);
        send_request(OP_IS_MIN,   6'd10, 6'd63);
        send_request(OP_IS_MIN,   6'd30, 6'd0);
        send_request(OP_DEL_MIN,  6'd30, 6'd0);   // not minimal
        send_request(OP_DEL_MIN,  6'd10, 6'd63);
        send_request(OP_GET_REL,  6'd10, 6'd30);
        send_request(OP_GET_REL,  6'd20, 6'd30);
        send_request(OP_SET_LESS, 6'd63, 6'd62);
        send_request(OP_GET_REL,  6'd0,  6'd62);
        send_request(OP_GET_REL,  6'd1,  6'd2);
        send_request(OP_DEL_MIN,  6'd0,  6'd0);
        send_request(OP_GET_REL,  6'd0,  6'd62);
        send_request(OP_IS_MIN,   6'd63, 6'd63);
        send_request(OP_SET_LESS, 6'd62, 6'd63);
    endtask

    // Walk node_count through its edges, including stale rows
    task automatic test_node_count_limits();
        set_node_count(7'd0);
        send_request(OP_IS_MIN,   6'd0, 6'd0);
        send_request(OP_SET_LESS, 6'd0, 6'd1);
        send_request(OP_GET_REL,  6'd0, 6'd0);
        send_request(OP_DEL_MIN,  6'd0, 6'd0);
        set_node_count(7'd1);
        send_request(OP_SET_LESS, 6'd0, 6'd0);
        send_request(OP_IS_MIN,   6'd0, 6'd63);   // second node ignored
        send_request(OP_GET_REL,  6'd0, 6'd1);
        send_request(OP_DEL_MIN,  6'd0, 6'd63);
        set_node_count(7'd127);
        send_request(OP_SET_LESS, 6'd40, 6'd1);
        send_request(OP_GET_REL,  6'd63, 6'd62);
        send_request(OP_IS_MIN,   6'd1,  6'd0);
        set_node_count(7'd2);
        send_request(OP_IS_MIN,   6'd1,  6'd0);   // stale node 40 still below
        send_request(OP_DEL_MIN,  6'd1,  6'd0);
        send_request(OP_GET_REL,  6'd1,  6'd40);
        send_request(OP_IS_MIN,   6'd40, 6'd0);
        send_request(OP_DEL_MIN,  6'd0,  6'd1);
        set_node_count(7'd65);
        send_request(OP_DEL_MIN,  6'd40, 6'd0);
        send_request(OP_DEL_MIN,  6'd1,  6'd0);
        set_node_count(7'd64);
    endtask

    // Random requests over a range of limits
    task automatic test_random_traffic();
        logic [CFG_W-1:0] counts [$];
        op_t              kind;
        node_t            node_a;
        node_t            node_b;
        int unsigned      lim;
        int unsigned      roll;
        int unsigned      items;
        int               minimal [$];
        int               p;
        int               n;
        int               x;
        counts = '{7'd64, 7'd8, 7'd127, 7'd3, 7'd16, 7'd64, 7'd0, 7'd32, 7'd2, 7'd64};
        counts.push_back(CFG_W'($urandom_range(1, 127)));
        for (p = 0; p < counts.size(); p++)
        begin
            set_node_count(counts[p]);
            items = (counts[p] == 0) ? 20 : PHASE_ITEMS;
            for (n = 0; n < items; n++)
            begin
                lim  = live_limit();
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    kind = OP_SET_LESS;
                else if (roll < 60)
                    kind = OP_GET_REL;
                else if (roll < 75)
                    kind = OP_IS_MIN;
                else
                    kind = OP_DEL_MIN;
                node_a = pick_node(lim);
                node_b = pick_node(lim);
                // Steer most deletes onto a minimal node
                if (kind == OP_DEL_MIN && $urandom_range(0, 3) != 0)
                begin
                    minimal = {};
                    for (x = 0; x < lim; x++)
                        if (order_below[x] == '0)
                            minimal.push_back(x);
                    if (minimal.size() != 0)
                        node_a = node_t'(minimal[$urandom_range(0, minimal.size() - 1)]);
                end
                // Occasional full-range indices
                if ($urandom_range(0, 9) == 0)
                begin
                    node_a = node_t'($urandom);
                    node_b = node_t'($urandom);
                end
                send_request(kind, node_a, node_b);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int r = 0; r < MAX_NODES; r++)
            order_below[r] = '0;
        nodes_in_use = CFG_W'(NODE_COUNT_RESET);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_node_count_limits();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
